// ----- design/mouse_button_event_classifier_defines.svh -----
// ----------------------------------------------------------------------------
// Mouse button event classifier: assertion macros
// Clocked assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef MOUSE_BUTTON_EVENT_CLASSIFIER_DEFINES_SVH
`define MOUSE_BUTTON_EVENT_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only out of reset
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mbec assertion failed");
// checked at every edge, reset included
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("mbec assertion failed");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_ALWAYS(label, prop)
`endif

`endif

// ----- design/mbec_pkg.sv -----
// ----------------------------------------------------------------------------
// Mouse button event classifier package
// Widths, register indexes and event codes shared by the classifier.
// ----------------------------------------------------------------------------
package mbec_pkg;

	localparam int COORD_BITS = 12;
	localparam int TIME_BITS  = 32;
	localparam int LIMIT_BITS = 16;
	localparam int MAX_EVENTS = 4;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_DX_LIMIT   = 2'd0,
		REG_DY_LIMIT   = 2'd1,
		REG_TIME_LIMIT = 2'd2
	} cfg_reg_t;

	// event kinds; button n adds EV_STEP * n
	localparam logic [3:0] EV_MOVE   = 4'd0;
	localparam logic [3:0] EV_DOWN   = 4'd1;
	localparam logic [3:0] EV_DOUBLE = 4'd2;
	localparam logic [3:0] EV_UP     = 4'd3;
	localparam logic [3:0] EV_STEP   = 4'd3;

	// press_button value for "no press recorded"
	localparam logic [1:0] NO_PRESS = 2'd0;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [TIME_BITS-1:0]  stamp_t;

	function automatic logic [3:0] button_code(input logic [1:0] btn, input logic [3:0] kind);
		return kind + EV_STEP * {2'b00, btn};
	endfunction

	function automatic coord_t coord_dist(input coord_t a, input coord_t b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

endpackage

// ----- design/mouse_button_event_classifier.sv -----
// ----------------------------------------------------------------------------
// Mouse button event classifier
// Turns raw mouse reports into move, down, double-click and up events.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | words
//   ---------+----------------------+-----------------------------------------
//   in       | in_valid / in_ready  | one mouse report per word
//   out      | out_valid / out_ready| one event per word, last_of_run on final
//   cfg      | cfg_we               | register write, index + data, no wait
//
// A report is classified in one pass from the input register into a result
// buffer; the buffer then sends its events one per cycle while out_ready
// is high, at most 4 events per report, over the single output port.
// The first event passes the input register and then the result buffer.
// The input register takes a new report while the buffer still drains.
// Reset clears the history, the recorded press and loads the limits 4, 4, 500.
// ----------------------------------------------------------------------------
`include "mouse_button_event_classifier_defines.svh"

module mouse_button_event_classifier
	import mbec_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [LIMIT_BITS-1:0] cfg_data,
	// reports
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] column,
	input  logic [COORD_BITS-1:0] row,
	input  logic [2:0]            buttons,
	input  logic [TIME_BITS-1:0]  stamp,
	input  logic [7:0]            shift_keys,
	input  logic                  target_found,
	// events
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [3:0]            event_code,
	output logic [COORD_BITS-1:0] out_column,
	output logic [COORD_BITS-1:0] out_row,
	output logic [2:0]            out_buttons,
	output logic [7:0]            out_shift_keys,
	output logic                  last_of_run
);

	// configuration registers
	coord_t                dx_limit_q;
	coord_t                dy_limit_q;
	logic [LIMIT_BITS-1:0] time_limit_q;

	// history state
	logic [2:0] prev_buttons_q;
	coord_t     prev_column_q;
	coord_t     prev_row_q;
	logic [1:0] press_button_q;
	stamp_t     press_time_q;
	coord_t     press_x_q;
	coord_t     press_y_q;

	// input register
	logic       valid_s1;
	coord_t     column_s1;
	coord_t     row_s1;
	logic [2:0] buttons_s1;
	stamp_t     stamp_s1;
	logic [7:0] shift_s1;
	logic       target_s1;

	// result buffer
	logic       res_valid_q;
	logic [3:0] res_code_q [MAX_EVENTS];
	logic [2:0] res_cnt_q;
	logic [1:0] res_idx_q;
	coord_t     res_column_q;
	coord_t     res_row_q;
	logic [2:0] res_buttons_q;
	logic [7:0] res_shift_q;

	logic res_last;
	logic out_fire;
	logic buf_free;
	logic s1_adv;

	// classification
	logic [2:0] rise;
	logic [2:0] fall;
	logic       any_rise;
	logic [1:0] first_rise;
	logic [1:0] last_rise;
	logic       moved;
	stamp_t     elapsed;
	logic       dbl;
	logic       cand_v    [MAX_EVENTS];
	logic [3:0] cand_code [MAX_EVENTS];
	logic [3:0] ev_code   [MAX_EVENTS];
	logic [2:0] ev_cnt;

	// handshake
	assign res_last = ({1'b0, res_idx_q} == (res_cnt_q - 3'd1));
	assign out_fire = res_valid_q && out_ready;
	assign buf_free = !res_valid_q || (out_ready && res_last);
	assign s1_adv   = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || buf_free;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_limit_q   <= COORD_BITS'(4);
			dy_limit_q   <= COORD_BITS'(4);
			time_limit_q <= LIMIT_BITS'(500);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DX_LIMIT:   dx_limit_q   <= cfg_data[COORD_BITS-1:0];
				REG_DY_LIMIT:   dy_limit_q   <= cfg_data[COORD_BITS-1:0];
				REG_TIME_LIMIT: time_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// capture report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			column_s1  <= column;
			row_s1     <= row;
			buttons_s1 <= buttons;
			stamp_s1   <= stamp;
			shift_s1   <= shift_keys;
			target_s1  <= target_found;
		end
	end

	// find edges and the pressed buttons
	always_comb begin
		rise       = buttons_s1 & ~prev_buttons_q;
		fall       = ~buttons_s1 & prev_buttons_q;
		any_rise   = |rise;
		first_rise = 2'd0;
		last_rise  = 2'd0;
		for (int n = 2; n >= 0; n--) begin
			if (rise[n]) first_rise = 2'(n);
		end
		for (int n = 0; n < 3; n++) begin
			if (rise[n]) last_rise = 2'(n);
		end
		moved   = (column_s1 != prev_column_q) || (row_s1 != prev_row_q);
		elapsed = stamp_s1 - press_time_q;
		// only the first press of a report can match the recorded one
		dbl = (press_button_q == (first_rise + 2'd1))
			&& (elapsed < stamp_t'(time_limit_q))
			&& (coord_dist(press_x_q, column_s1) < dx_limit_q)
			&& (coord_dist(press_y_q, row_s1) < dy_limit_q);
	end

	// build the ordered event list
	always_comb begin
		cand_v[0]    = target_s1 && moved;
		cand_code[0] = EV_MOVE;
		for (int n = 0; n < 3; n++) begin
			cand_v[n+1] = target_s1 && (rise[n] || fall[n]);
			if (rise[n]) begin
				cand_code[n+1] = button_code(2'(n),
					(dbl && first_rise == 2'(n)) ? EV_DOUBLE : EV_DOWN);
			end else begin
				cand_code[n+1] = button_code(2'(n), EV_UP);
			end
		end
		for (int i = 0; i < MAX_EVENTS; i++) begin
			ev_code[i] = EV_MOVE;
		end
		ev_cnt = 3'd0;
		for (int i = 0; i < MAX_EVENTS; i++) begin
			if (cand_v[i]) begin
				ev_code[ev_cnt[1:0]] = cand_code[i];
				ev_cnt = ev_cnt + 3'd1;
			end
		end
	end

	// advance history on every report, presses only with a target
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_buttons_q <= '0;
			prev_column_q  <= '0;
			prev_row_q     <= '0;
			press_button_q <= NO_PRESS;
			press_time_q   <= '0;
			press_x_q      <= '0;
			press_y_q      <= '0;
		end else if (s1_adv) begin
			prev_buttons_q <= buttons_s1;
			prev_column_q  <= column_s1;
			prev_row_q     <= row_s1;
			if (target_s1 && any_rise) begin
				press_button_q <= last_rise + 2'd1;
				press_time_q   <= stamp_s1;
				press_x_q      <= column_s1;
				press_y_q      <= row_s1;
			end
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			res_cnt_q   <= 3'd0;
			res_idx_q   <= 2'd0;
		end else if (s1_adv) begin
			res_valid_q <= (ev_cnt != 3'd0);
			res_cnt_q   <= ev_cnt;
			res_idx_q   <= 2'd0;
		end else if (out_fire) begin
			if (res_last) begin
				res_valid_q <= 1'b0;
			end else begin
				res_idx_q <= res_idx_q + 2'd1;
			end
		end
	end

	// load event words
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			for (int i = 0; i < MAX_EVENTS; i++) begin
				res_code_q[i] <= ev_code[i];
			end
			res_column_q  <= column_s1;
			res_row_q     <= row_s1;
			res_buttons_q <= buttons_s1;
			res_shift_q   <= shift_s1;
		end
	end

	assign out_valid      = res_valid_q;
	assign event_code     = res_code_q[res_idx_q];
	assign out_column     = res_column_q;
	assign out_row        = res_row_q;
	assign out_buttons    = res_buttons_q;
	assign out_shift_keys = res_shift_q;
	assign last_of_run    = res_last;

	// checks
	`ASSERT_ALWAYS(a_reset_empty, !arst_n |=> (!res_valid_q && !valid_s1))
	`ASSERT_CLK(a_idx_in_run, res_valid_q |-> (res_cnt_q != 3'd0 && {1'b0, res_idx_q} < res_cnt_q))
	`ASSERT_CLK(a_run_continues, (out_fire && !res_last) |=> res_valid_q)
	`ASSERT_CLK(a_no_target_keeps_press, (s1_adv && !target_s1) |=> $stable(press_button_q))
	`ASSERT_CLK(a_no_target_no_words, (s1_adv && !target_s1) |=> !res_valid_q)

endmodule

// ----- dv/mbec_event_checker.sv -----
// ----------------------------------------------------------------------------
// Mouse event checker
// Watches the register port and both word channels of the classifier. It keeps
// its own copy of the history, the last press and the limits, works out the
// events of every accepted report, and compares each event word field by
// field with the oldest one still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mbec_event_checker
	import mbec_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [LIMIT_BITS-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [COORD_BITS-1:0] column,
	input  logic [COORD_BITS-1:0] row,
	input  logic [2:0]            buttons,
	input  logic [TIME_BITS-1:0]  stamp,
	input  logic [7:0]            shift_keys,
	input  logic                  target_found,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [3:0]            event_code,
	input  logic [COORD_BITS-1:0] out_column,
	input  logic [COORD_BITS-1:0] out_row,
	input  logic [2:0]            out_buttons,
	input  logic [7:0]            out_shift_keys,
	input  logic                  last_of_run,
	output int                    fail_count,
	output int                    events_owed,
	output int                    events_checked,
	output int                    doubles_seen
);

	typedef struct packed {
		coord_t      column;
		coord_t      row;
		logic [2:0]  buttons;
		stamp_t      stamp;
		logic [7:0]  shift_keys;
		logic        target_found;
	} mouse_report_t;

	typedef struct packed {
		logic [3:0]  code;
		coord_t      column;
		coord_t      row;
		logic [2:0]  buttons;
		logic [7:0]  shift_keys;
		logic        last;
	} mouse_event_t;

	// limits as last written
	logic [COORD_BITS-1:0] dx_limit = 12'd4;
	logic [COORD_BITS-1:0] dy_limit = 12'd4;
	logic [LIMIT_BITS-1:0] window   = 16'd500;

	// history of the previous report and the last recorded press
	logic [2:0]  seen_buttons = '0;
	coord_t      seen_column  = '0;
	coord_t      seen_row     = '0;
	logic [1:0]  press_btn    = NO_PRESS;
	stamp_t      press_stamp  = '0;
	coord_t      press_col    = '0;
	coord_t      press_row    = '0;

	mouse_event_t pending_events [$];

	function automatic coord_t axis_gap(input coord_t a, input coord_t b);
		return (a > b) ? a - b : b - a;
	endfunction

	// work out the events of one report and advance the history
	function automatic void classify_report(input mouse_report_t rep);
		logic [3:0]   codes [MAX_EVENTS];
		int           k;
		logic         dbl;
		logic [1:0]   btn_id;
		stamp_t       age;
		mouse_event_t ev;
		k = 0;
		if (rep.target_found) begin
			if (rep.column != seen_column || rep.row != seen_row) begin
				codes[k] = EV_MOVE;
				k++;
			end
			for (int n = 0; n < 3; n++) begin
				btn_id = 2'(n + 1);
				if (!seen_buttons[n] && rep.buttons[n]) begin
					// press: double only against a close, recent press of the same button
					age = rep.stamp - press_stamp;
					dbl = (press_btn == btn_id) && (age < stamp_t'(window)) &&
						(axis_gap(press_col, rep.column) < dx_limit) &&
						(axis_gap(press_row, rep.row) < dy_limit);
					codes[k] = (dbl ? EV_DOUBLE : EV_DOWN) + EV_STEP * 4'(n);
					k++;
					press_btn   = btn_id;
					press_stamp = rep.stamp;
					press_col   = rep.column;
					press_row   = rep.row;
				end else if (seen_buttons[n] && !rep.buttons[n]) begin
					codes[k] = EV_UP + EV_STEP * 4'(n);
					k++;
				end
			end
		end
		for (int i = 0; i < k; i++) begin
			ev.code       = codes[i];
			ev.column     = rep.column;
			ev.row        = rep.row;
			ev.buttons    = rep.buttons;
			ev.shift_keys = rep.shift_keys;
			ev.last       = (i == k - 1);
			pending_events.push_back(ev);
		end
		seen_buttons = rep.buttons;
		seen_column  = rep.column;
		seen_row     = rep.row;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// track register writes, check event words, predict on accepted reports
	always @(posedge clk or negedge arst_n) begin : track
		mouse_event_t  want;
		mouse_report_t rep;
		if (!arst_n) begin
			dx_limit       = 12'd4;
			dy_limit       = 12'd4;
			window         = 16'd500;
			seen_buttons   = '0;
			seen_column    = '0;
			seen_row       = '0;
			press_btn      = NO_PRESS;
			press_stamp    = '0;
			press_col      = '0;
			press_row      = '0;
			pending_events.delete();
			fail_count     = 0;
			events_owed    = 0;
			events_checked = 0;
			doubles_seen   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_DX_LIMIT:   dx_limit = cfg_data[COORD_BITS-1:0];
					REG_DY_LIMIT:   dy_limit = cfg_data[COORD_BITS-1:0];
					REG_TIME_LIMIT: window = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (pending_events.size() == 0) begin
					$error("event word with none owed: code %0d", event_code);
					fail_count++;
				end else begin
					want = pending_events.pop_front();
					check_field("event_code", want.code, event_code);
					check_field("out_column", want.column, out_column);
					check_field("out_row", want.row, out_row);
					check_field("out_buttons", want.buttons, out_buttons);
					check_field("out_shift_keys", want.shift_keys, out_shift_keys);
					check_field("last_of_run", want.last, last_of_run);
					events_checked++;
					if (want.code != EV_MOVE &&
						(want.code - EV_DOWN) % EV_STEP == EV_DOUBLE - EV_DOWN)
						doubles_seen++;
				end
			end
			if (in_valid && in_ready) begin
				rep = '{column, row, buttons, stamp, shift_keys, target_found};
				classify_report(rep);
			end
			events_owed = pending_events.size();
		end
	end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Mouse button event classifier testbench
// Sends a directed set of reports (clicks, double clicks, wrapped and stale
// stamps, reports with no target, all buttons at once), then random click
// sequences and noise under several limit settings, with random gaps on both
// channels and one long stall of the event side. The checker module does
// all prediction and comparison; this top drives and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import mbec_pkg::*;

	localparam int RESET_CYCLES = 9;
	localparam int WATCHDOG     = 3000;
	localparam int LONG_HOLD    = 300;
	localparam int SETTLE       = 6;
	localparam int PHASES       = 5;
	localparam int PHASE_ITEMS  = 90;
	// index past the last register, must be ignored
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic                  clk            = 1'b0;
	logic                  arst_n         = 1'b0;
	logic                  cfg_we         = 1'b0;
	logic [1:0]            cfg_index      = '0;
	logic [LIMIT_BITS-1:0] cfg_data       = '0;
	logic                  in_valid       = 1'b0;
	logic                  in_ready;
	logic [COORD_BITS-1:0] column         = '0;
	logic [COORD_BITS-1:0] row            = '0;
	logic [2:0]            buttons        = '0;
	logic [TIME_BITS-1:0]  stamp          = '0;
	logic [7:0]            shift_keys     = '0;
	logic                  target_found   = 1'b0;
	logic                  out_valid;
	logic                  out_ready      = 1'b0;
	logic [3:0]            event_code;
	logic [COORD_BITS-1:0] out_column;
	logic [COORD_BITS-1:0] out_row;
	logic [2:0]            out_buttons;
	logic [7:0]            out_shift_keys;
	logic                  last_of_run;

	int fail_count;
	int events_owed;
	int events_checked;
	int doubles_seen;

	logic in_taken    = 1'b0;
	bit   squeeze     = 1'b0;
	bit   squeezed    = 1'b0;
	int   calm_items  = 0;
	int   reports_sent = 0;
	int   reg_writes  = 0;
	int   idle_cycles = 0;

	mouse_button_event_classifier u_dut (.*);
	mbec_event_checker u_checker (.*);

	always #2 clk = ~clk;

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
	end

	// note accepted reports for the sender, which looks at falling edges
	always @(posedge clk) in_taken <= in_valid && in_ready;

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG) begin
			$display("simulation failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int sender_gap();
		if (calm_items > 0) begin
			calm_items--;
			return 0;
		end
		if ($urandom_range(0, 99) < 8) begin
			calm_items = $urandom_range(30, 60);
			return 0;
		end
		return pick_gap();
	endfunction

	// offer one report word and hold it until taken
	task automatic offer(input coord_t c, input coord_t r, input logic [2:0] b,
		input stamp_t s, input logic [7:0] sh, input logic tgt);
		int g;
		g = sender_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		column       <= c;
		row          <= r;
		buttons      <= b;
		stamp        <= s;
		shift_keys   <= sh;
		target_found <= tgt;
		in_valid     <= 1'b1;
		do @(negedge clk); while (!in_taken);
		reports_sent++;
	endtask

	// drop valid and wait until every owed event has left the block
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (events_owed != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [LIMIT_BITS-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		reg_writes++;
	endtask

	// load all limits, with junk in the unused upper bits, plus a stray index
	task automatic load_limits(input int dx, input int dy, input int tl);
		wait_idle();
		write_reg(REG_DX_LIMIT, {4'($urandom), 12'(dx)});
		write_reg(REG_DY_LIMIT, {4'($urandom), 12'(dy)});
		write_reg(REG_TIME_LIMIT, 16'(tl));
		write_reg(REG_UNUSED, 16'($urandom));
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// event side: random stalls, calm stretches, and one long hold-off
	initial begin : receiver
		int hold_left;
		int g;
		int calm_left;
		hold_left = 0;
		calm_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (squeeze && !squeezed) begin
				squeezed = 1'b1;
				out_ready <= 1'b0;
				hold_left = LONG_HOLD - 1;
			end else if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (calm_left > 0) begin
				out_ready <= 1'b1;
				calm_left--;
			end else if ($urandom_range(0, 99) < 6) begin
				calm_left = $urandom_range(30, 80);
				out_ready <= 1'b1;
			end else begin
				g = pick_gap();
				out_ready <= (g == 0);
				if (g > 0)
					hold_left = g - 1;
			end
		end
	end

	initial begin : stimulus
		int     dx_set [PHASES] = '{4, 0, 4095, 1, 0};
		int     dy_set [PHASES] = '{4, 0, 4095, 1, 0};
		int     tl_set [PHASES] = '{500, 0, 65535, 1, 0};
		coord_t cur_col;
		coord_t cur_row;
		logic [2:0] cur_btn;
		stamp_t cur_stamp;
		int     mode;
		int     tl;
		int     n;
		cur_col   = 12'd100;
		cur_row   = 12'd100;
		cur_btn   = '0;
		cur_stamp = 32'd5000;
		@(posedge arst_n);
		@(negedge clk);

		// directed reports under the reset limits 4, 4, 500
		offer(0, 0, 3'b000, 32'd0, 8'h00, 1'b1);
		offer(100, 100, 3'b001, 32'd1000, 8'h00, 1'b1);
		offer(100, 100, 3'b000, 32'd1100, 8'h01, 1'b1);
		offer(103, 97, 3'b001, 32'd1300, 8'h02, 1'b1);
		offer(103, 97, 3'b000, 32'd1350, 8'h04, 1'b1);
		offer(103, 97, 3'b001, 32'd1799, 8'h08, 1'b1);
		offer(103, 97, 3'b000, 32'd1800, 8'h10, 1'b1);
		offer(103, 97, 3'b001, 32'd2299, 8'h20, 1'b1);
		offer(107, 97, 3'b000, 32'd2300, 8'h40, 1'b1);
		offer(107, 97, 3'b001, 32'd2310, 8'h80, 1'b1);
		offer(107, 101, 3'b000, 32'd2320, 8'h00, 1'b1);
		offer(107, 101, 3'b001, 32'd2330, 8'h00, 1'b1);
		// release one button and press another in the same report
		offer(107, 101, 3'b010, 32'd2340, 8'h00, 1'b1);
		offer(107, 101, 3'b000, 32'd2350, 8'h00, 1'b1);
		// all three buttons at once, field maxima
		offer(4095, 4095, 3'b111, 32'hFFFF_FF00, 8'hFF, 1'b1);
		offer(4095, 4095, 3'b000, 32'hFFFF_FF10, 8'hA5, 1'b1);
		// stamp wrapped since the last press
		offer(4095, 4095, 3'b100, 32'h0000_0010, 8'h5A, 1'b1);
		// no target: history moves on, recorded press stays
		offer(0, 0, 3'b000, 32'h0000_0020, 8'h00, 1'b0);
		offer(0, 0, 3'b100, 32'h0000_0030, 8'h00, 1'b0);
		offer(4095, 4095, 3'b000, 32'h0000_0040, 8'h33, 1'b1);
		// stamp earlier than the recorded press
		offer(4095, 4095, 3'b100, 32'hFFFF_FFFF, 8'hCC, 1'b1);
		offer(4095, 4095, 3'b000, 32'hFFFF_FFFF, 8'h00, 1'b1);
		offer(4095, 4095, 3'b100, 32'h0000_0000, 8'h00, 1'b1);
		offer(2048, 1024, 3'b011, 32'h8000_0000, 8'h3C, 1'b1);
		offer(2048, 1024, 3'b000, 32'h8000_0001, 8'hC3, 1'b1);

		// random click sequences and noise under each limit setting
		for (int p = 0; p < PHASES; p++) begin
			if (p == PHASES - 1) begin
				dx_set[p] = $urandom_range(2, 32);
				dy_set[p] = $urandom_range(2, 32);
				tl_set[p] = $urandom_range(50, 3000);
			end
			load_limits(dx_set[p], dy_set[p], tl_set[p]);
			tl = tl_set[p];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 0 && i == 20)
					squeeze = 1'b1;
				mode = $urandom_range(0, 99);
				if (mode < 70) begin
					// click: toggle a button near the last spot, shortly after
					n = $urandom_range(0, 2);
					if ($urandom_range(0, 9) == 0)
						cur_btn = 3'($urandom);
					else
						cur_btn[n] = ~cur_btn[n];
					cur_col = cur_col + coord_t'($urandom_range(0, 10)) - coord_t'(5);
					cur_row = cur_row + coord_t'($urandom_range(0, 10)) - coord_t'(5);
					if ($urandom_range(0, 3) != 0)
						cur_stamp = cur_stamp + stamp_t'($urandom_range(0, tl + tl / 2 + 2));
				end else if (mode < 85) begin
					// move only
					cur_col = cur_col + coord_t'($urandom_range(0, 63));
					cur_row = cur_row + coord_t'($urandom_range(0, 63));
					cur_stamp = cur_stamp + stamp_t'($urandom_range(0, 100));
				end else begin
					// noise over the full range of every field
					cur_col   = coord_t'($urandom);
					cur_row   = coord_t'($urandom);
					cur_btn   = 3'($urandom);
					cur_stamp = $urandom;
				end
				offer(cur_col, cur_row, cur_btn, cur_stamp, 8'($urandom),
					$urandom_range(0, 99) < 92);
			end
		end

		wait_idle();
		$display("covered %0d reports over %0d limit settings, %0d register writes",
			reports_sent, PHASES + 1, reg_writes);
		$display("checked %0d event words, %0d of them double clicks",
			events_checked, doubles_seen);
		if (fail_count == 0 && events_owed == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+design
design/mbec_pkg.sv
design/mouse_button_event_classifier.sv
dv/mbec_event_checker.sv
dv/tb.sv
